// ===== rtl/core/cdfis_pkg.sv =====
// shared types and constants for the cdf importance sampler
package cdfis_pkg;

  localparam int CMD_W      = 2;
  localparam int WEIGHT_W   = 16;
  localparam int XI_W       = 16;
  localparam int SUM_W      = 32;
  localparam int PIX_W      = 8;
  localparam int DIV_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [DIV_W-1:0]     WIDTH_RESET     = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cdfis_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SRCH,
    ST_CMP,
    ST_FIX,
    ST_PREV,
    ST_DIFF,
    ST_DIV,
    ST_DONE
  } cdfis_state_t;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic clear;
    logic query;
    logic mul;
    logic rd_mid;
    logic step;
    logic rd_idx;
    logic rd_prev;
    logic diff;
    logic load_out;
  } cdfis_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic search_done;
    logic div_busy;
    logic out_free;
  } cdfis_sts_t;

endpackage

// ===== rtl/core/cdfis_req_if.sv =====
// request channel: command, weight and uniform value
interface cdfis_req_if import cdfis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [WEIGHT_W-1:0] weight;
  logic [XI_W-1:0]     uniform_value;

  modport source (output valid, cmd, weight, uniform_value, input ready);
  modport sink (input valid, cmd, weight, uniform_value, output ready);
endinterface

// ===== rtl/core/cdfis_rsp_if.sv =====
// response channel: selected pixel, its weight and status
interface cdfis_rsp_if import cdfis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    column;
  logic [PIX_W-1:0]    row;
  logic [WEIGHT_W-1:0] picked_weight;
  logic                status;

  modport source (output valid, column, row, picked_weight, status, input ready);
  modport sink (input valid, column, row, picked_weight, status, output ready);
endinterface

// ===== rtl/core/cdfis_div.sv =====
// restoring divider, one quotient bit per cycle, for index to row and column
module cdfis_div import cdfis_pkg::*; #(
  parameter int QW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW-1:0]    dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [QW-1:0]    quot,
  output logic [DIV_W-1:0] rem
);

  localparam int SW = $clog2(QW + 1);

  logic [SW-1:0]    steps;
  logic [DIV_W+1:0] trial;
  logic             ge;

  assign trial = {1'b0, rem, quot[QW-1]} - {2'b00, divisor};
  assign ge    = ~trial[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && steps == SW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= dividend;
      rem   <= '0;
      steps <= SW'(QW);
    end else if (busy) begin
      steps <= steps - SW'(1);
      quot  <= {quot[QW-2:0], ge};
      rem   <= ge ? trial[DIV_W-1:0] : {rem[DIV_W-2:0], quot[QW-1]};
    end
  end

endmodule

// ===== rtl/core/cdfis_dp.sv =====
// datapath: prefix sum memory, totals, binary search, divider and output register
module cdfis_dp import cdfis_pkg::*; #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [WEIGHT_W-1:0]   weight,
  input  logic [XI_W-1:0]       uniform_value,
  input  cdfis_ctl_t            ctl,
  output cdfis_sts_t            sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      column,
  output logic [PIX_W-1:0]      row,
  output logic [WEIGHT_W-1:0]   picked_weight,
  output logic                  status
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int QW = (AW > PIX_W) ? AW : PIX_W;
  localparam int TW = SUM_W + XI_W;

  logic [SUM_W-1:0]    mem [MAX_PIXELS];
  logic [AW-1:0]       rd_addr;
  logic [SUM_W-1:0]    rd_data;

  logic [CW-1:0]       count;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       clamp_lo;
  logic                full;
  logic [SUM_W-1:0]    total;
  logic [SUM_W:0]      total_sum;
  logic [SUM_W-1:0]    total_sat;
  logic [XI_W-1:0]     xi;
  logic [TW-1:0]       target;
  logic [AW-1:0]       idx;
  logic [WEIGHT_W-1:0] cur_lo;
  logic [WEIGHT_W-1:0] picked;
  logic                err;
  logic [DIV_W-1:0]    width_reg;
  logic [DIV_W-1:0]    divisor;
  logic                div_busy;
  logic [QW-1:0]       quot;
  logic [DIV_W-1:0]    rem;

  assign full      = (count == CW'(MAX_PIXELS));
  assign total_sum = {1'b0, total} + (SUM_W + 1)'(weight);
  // prefix sums saturate at all ones
  assign total_sat = total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];
  assign mid       = lo + ((hi - lo) >> 1);
  // no qualifying pixel falls back to the last loaded one
  assign clamp_lo  = (lo >= count) ? count - CW'(1) : lo;
  assign divisor   = (width_reg == '0) ? DIV_W'(1) : width_reg;

  always_comb begin
    priority if (ctl.rd_mid) begin
      rd_addr = mid[AW-1:0];
    end else if (ctl.rd_idx) begin
      rd_addr = clamp_lo[AW-1:0];
    end else begin
      rd_addr = (idx == '0) ? '0 : idx - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append && !full) begin
      mem[count[AW-1:0]] <= total_sat;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      width_reg <= WIDTH_RESET;
    end else begin
      // image height has no effect on sampling, so only the width is kept
      if (cfg_we && cfg_index == CFG_IMAGE_WIDTH) begin
        width_reg <= cfg_data;
      end
      if (ctl.clear) begin
        count <= '0;
        total <= '0;
      end else if (ctl.append && !full) begin
        count <= count + CW'(1);
        total <= total_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.query) begin
      xi  <= uniform_value;
      err <= sts.empty;
    end
    if (ctl.mul) begin
      target <= xi * total;
    end
    if (ctl.mul) begin
      lo <= '0;
      hi <= count;
    end else if (ctl.step) begin
      // unnormalized compare: sum * 65536 against xi * total
      if ({rd_data, {XI_W{1'b0}}} > target) begin
        hi <= mid;
      end else begin
        lo <= mid + CW'(1);
      end
    end
    if (ctl.rd_idx) begin
      idx <= clamp_lo[AW-1:0];
    end
    if (ctl.rd_prev) begin
      cur_lo <= rd_data[WEIGHT_W-1:0];
    end
    if (ctl.diff) begin
      picked <= cur_lo - ((idx == '0) ? '0 : rd_data[WEIGHT_W-1:0]);
    end
  end

  cdfis_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.diff),
    .dividend (QW'(idx)),
    .divisor  (divisor),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      if (err) begin
        column        <= '0;
        row           <= '0;
        picked_weight <= '0;
        status        <= 1'b1;
      end else begin
        column        <= rem[PIX_W-1:0];
        row           <= quot[PIX_W-1:0];
        picked_weight <= picked;
        status        <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.empty       = (count == '0) || (total == '0);
    sts.search_done = !(lo < hi);
    sts.div_busy    = div_busy;
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/cdfis_ctrl.sv =====
// controller state machine: request decode, search sequencing, divide and output
module cdfis_ctrl import cdfis_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] req_cmd,
  output logic             req_ready,
  input  cdfis_sts_t       sts,
  output cdfis_ctl_t       ctl
);

  cdfis_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_cmd)
            CMD_APPEND: ctl.append = 1'b1;
            CMD_CLEAR:  ctl.clear = 1'b1;
            CMD_SAMPLE: begin
              ctl.query  = 1'b1;
              // empty or zero table answers at once with an error
              state_next = sts.empty ? ST_DONE : ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_SRCH;
      end
      ST_SRCH: begin
        if (sts.search_done) begin
          state_next = ST_FIX;
        end else begin
          ctl.rd_mid = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.step   = 1'b1;
        state_next = ST_SRCH;
      end
      ST_FIX: begin
        ctl.rd_idx = 1'b1;
        state_next = ST_PREV;
      end
      ST_PREV: begin
        ctl.rd_prev = 1'b1;
        state_next  = ST_DIFF;
      end
      ST_DIFF: begin
        ctl.diff   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/cdf_importance_sampler_unit.sv =====
// top level of the cdf importance sampler
//
//   channel   dir  handshake        contents
//   req       in   valid / ready    cmd, weight, uniform_value
//   rsp       out  valid / ready    column, row, picked_weight, status
//   cfg       in   cfg_we           cfg_index, cfg_data (image width, image height)
//
// append and clear requests are done in ST_IDLE as they are taken; a sample request
// runs the binary search (ST_SRCH and ST_CMP in turn), then the divider, and its
// response is loaded in ST_DONE once the output register is free; the next request is
// then taken; an empty or zero table goes straight to ST_DONE with an error response.
// reset clears count and total, sets the width to 256; memory contents stay undefined.
// a finished response waits in its output register while the next request is taken.
module cdf_importance_sampler_unit import cdfis_pkg::*; #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdfis_req_if.sink             req,
  cdfis_rsp_if.source           rsp
);

  cdfis_ctl_t ctl;
  cdfis_sts_t sts;

  cdfis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cdfis_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .weight        (req.weight),
    .uniform_value (req.uniform_value),
    .ctl           (ctl),
    .sts           (sts),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .column        (rsp.column),
    .row           (rsp.row),
    .picked_weight (rsp.picked_weight),
    .status        (rsp.status)
  );

endmodule

// ===== rtl/core/cdfis_checker.sv =====
// port-level checks for the cdf importance sampler, bound to the top level
module cdfis_checker import cdfis_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [CMD_W-1:0]    req_cmd,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [PIX_W-1:0]    rsp_column,
  input logic [PIX_W-1:0]    rsp_row,
  input logic [WEIGHT_W-1:0] rsp_picked_weight,
  input logic                rsp_status
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column) && $stable(rsp_row) &&
      $stable(rsp_picked_weight) && $stable(rsp_status))
    else $error("stalled response changed");

  // error responses carry no pixel
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_column == '0 && rsp_row == '0 &&
      rsp_picked_weight == '0)
    else $error("error response with nonzero fields");

  // a sample request keeps the block busy for at least the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_SAMPLE |=> !req_ready)
    else $error("request taken right after a sample");

  // a new response is only produced while a sample is in progress
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared without a sample in progress");

endmodule

bind cdf_importance_sampler_unit cdfis_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_cmd           (req.cmd),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_column        (rsp.column),
  .rsp_row           (rsp.row),
  .rsp_picked_weight (rsp.picked_weight),
  .rsp_status        (rsp.status)
);
